@@ hw/rtl/nppd_pkg.sv @@
// ---------------------------------------------------------------------------
// nppd_pkg: shared types and constants for the Netpbm pixel decoder
// Event format passed from the front end to the back end, status codes and
// the decoded configuration bundle.
// ---------------------------------------------------------------------------
`default_nettype none
package nppd_pkg;

  localparam logic [1:0] EV_SAMPLE = 2'd0;
  localparam logic [1:0] EV_BITS   = 2'd1;
  localparam logic [1:0] EV_EOD    = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CORRUPT = 2'd1;
  localparam logic [1:0] ST_TRUNC   = 2'd2;

  localparam logic [1:0] FMT_BITMAP = 2'd0;

  localparam logic [2:0] REG_FORMAT = 3'd0;
  localparam logic [2:0] REG_ASCII  = 3'd1;
  localparam logic [2:0] REG_MAXV   = 3'd2;
  localparam logic [2:0] REG_WIDTH  = 3'd3;
  localparam logic [2:0] REG_HEIGHT = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [16:0] data;   // raw sample, or the bitmap byte in [7:0]
    logic        bad;
    logic        eod;
  } ev_t;

  typedef struct packed {
    logic [1:0]  fmt;
    logic        ascii;
    logic        wide;    // effective maximum above 255
    logic [15:0] maxv;    // effective maximum (1 for bitmaps)
    logic [15:0] width;   // effective width
    logic        chans3;
    logic [33:0] total;   // samples in the image
  } cfg_t;

endpackage
`default_nettype wire

@@ hw/rtl/nppd_front.sv @@
// ---------------------------------------------------------------------------
// nppd_front: byte classifier
// Tokenizes ASCII data, pairs 16-bit binary bytes and turns each accepted
// byte into at most two events for the back end.
// ---------------------------------------------------------------------------
`default_nettype none
module nppd_front (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire nppd_pkg::cfg_t      cfg,
  input  wire                logic in_valid,
  output                     logic in_stall,
  input  wire                logic [7:0] data_byte,
  input  wire                logic end_of_data,
  output                     logic push_valid,
  output nppd_pkg::ev_t            push_ev,
  input  wire                logic q_full
);
  import nppd_pkg::*;

  logic        tok, com, bad, phase;
  logic [16:0] tv;
  logic [7:0]  hold;
  logic        pend_valid;
  ev_t         pend;

  logic        accept;
  logic        ev_a_v, ev_b_v;
  ev_t         ev_a, ev_b;
  logic        t_tok, t_com, t_bad;
  logic [16:0] t_tv;
  logic        ws, hash, digit;
  logic [20:0] prod;

  assign in_stall = pend_valid || q_full;
  assign accept   = in_valid && !in_stall;

  assign ws    = (data_byte == 8'd32) || (data_byte >= 8'd9 && data_byte <= 8'd13);
  assign hash  = data_byte == 8'h23;
  assign digit = data_byte >= 8'h30 && data_byte <= 8'h39;
  assign prod  = {1'b0, tv, 3'b0} + {3'b0, tv, 1'b0} + {17'b0, data_byte[3:0] - 4'h0};

  always_comb begin
    t_tok  = tok;
    t_com  = com;
    t_bad  = bad;
    t_tv   = tv;
    ev_a_v = 1'b0;
    ev_a   = '{kind: EV_SAMPLE, data: tv, bad: bad, eod: end_of_data};
    ev_b_v = end_of_data;
    ev_b   = '{kind: EV_EOD, data: 17'd0, bad: 1'b0, eod: 1'b1};
    if (cfg.ascii) begin
      if (com) begin
        if (data_byte == 8'd10 || data_byte == 8'd13) t_com = 1'b0;
      end else if (ws || hash) begin
        if (tok) begin
          ev_a_v = 1'b1;
          t_tv   = 17'd0;
          t_tok  = 1'b0;
          t_bad  = 1'b0;
        end
        if (hash) t_com = 1'b1;
      end else begin
        t_tok = 1'b1;
        if (digit) begin
          t_tv = (prod > 21'd65536) ? 17'd65536 : prod[16:0];
        end else begin
          t_bad = 1'b1;
        end
      end
      // open token closes at end of data
      if (end_of_data && t_tok) begin
        ev_a_v = 1'b1;
        ev_a   = '{kind: EV_SAMPLE, data: t_tv, bad: t_bad, eod: 1'b1};
        t_tv   = 17'd0;
        t_tok  = 1'b0;
        t_bad  = 1'b0;
      end
    end else if (cfg.fmt == FMT_BITMAP) begin
      ev_a_v = 1'b1;
      ev_a   = '{kind: EV_BITS, data: {9'd0, data_byte}, bad: 1'b0, eod: end_of_data};
    end else if (cfg.wide) begin
      ev_a_v = phase;
      ev_a   = '{kind: EV_SAMPLE, data: {1'b0, hold, data_byte}, bad: 1'b0,
                 eod: end_of_data};
    end else begin
      ev_a_v = 1'b1;
      ev_a   = '{kind: EV_SAMPLE, data: {9'd0, data_byte}, bad: 1'b0, eod: end_of_data};
    end
  end

  always_comb begin
    push_valid = 1'b0;
    push_ev    = pend;
    if (pend_valid) begin
      push_valid = !q_full;
    end else if (accept) begin
      push_valid = ev_a_v || ev_b_v;
      push_ev    = ev_a_v ? ev_a : ev_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok        <= 1'b0;
      com        <= 1'b0;
      bad        <= 1'b0;
      tv         <= 17'd0;
      phase      <= 1'b0;
      hold       <= 8'd0;
      pend_valid <= 1'b0;
    end else begin
      if (pend_valid && !q_full) pend_valid <= 1'b0;
      if (accept) begin
        tok <= t_tok;
        com <= t_com;
        bad <= t_bad;
        tv  <= t_tv;
        if (!cfg.ascii && cfg.fmt != FMT_BITMAP && cfg.wide) begin
          phase <= !phase;
          if (!phase) hold <= data_byte;
        end
        if (ev_a_v && ev_b_v) begin
          pend_valid <= 1'b1;
          pend       <= ev_b;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/nppd_queue.sv @@
// ---------------------------------------------------------------------------
// nppd_queue: event FIFO
// Small FIFO between the classifier and the sample engine.
// ---------------------------------------------------------------------------
`default_nettype none
module nppd_queue #(
  parameter int DEPTH = 4
) (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire                logic push_valid,
  input  wire nppd_pkg::ev_t       push_ev,
  output                     logic full,
  output                     logic pop_valid,
  output nppd_pkg::ev_t            pop_ev,
  input  wire                logic pop
);
  import nppd_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  ev_t           mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [CW-1:0] cnt;
  logic          do_push, do_pop;

  assign full      = cnt == CW'(DEPTH);
  assign pop_valid = cnt != '0;
  assign pop_ev    = mem[rp];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= push_ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (do_pop)  rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      if (do_push && !do_pop)      cnt <= cnt + 1'b1;
      else if (do_pop && !do_push) cnt <= cnt - 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/nppd_back.sv @@
// ---------------------------------------------------------------------------
// nppd_back: sample engine
// Range checks, rescales through a radix-2 divider, unpacks bitmap bytes,
// tracks image position and drives the output register.
// ---------------------------------------------------------------------------
`default_nettype none
module nppd_back (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire nppd_pkg::cfg_t      cfg,
  input  wire                logic q_valid,
  input  wire nppd_pkg::ev_t       q_ev,
  output                     logic pop,
  output                     logic out_valid,
  input  wire                logic out_stall,
  output                     logic [15:0] sample_value,
  output                     logic [1:0] channel_index,
  output                     logic [1:0] status,
  output                     logic last_sample
);
  import nppd_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_EMIT = 3'd2;
  localparam logic [2:0] S_ERR  = 3'd3;
  localparam logic [2:0] S_BITS = 3'd4;

  logic [2:0]  state;
  logic        finished;
  logic [33:0] samples_done;
  logic [1:0]  chan_pos;
  logic [15:0] column_count;
  logic [15:0] val;
  logic        ret_bits;
  logic [7:0]  bits_byte;
  logic [3:0]  bit_idx, bit_cnt;
  logic [1:0]  err_st;
  logic [15:0] rem, nq;
  logic [3:0]  div_cnt;

  logic        out_free;
  logic        emit_go;
  logic [15:0] colw, cols_left;
  logic [3:0]  cnt8;
  logic [31:0] numer;
  logic [16:0] trial;
  logic        qbit;
  logic [1:0]  ch, ch_next;
  logic        last;
  logic [16:0] col_sum;

  assign out_free = !out_valid || !out_stall;
  assign emit_go  = out_free && (state == S_EMIT || state == S_ERR);
  assign pop      = state == S_IDLE;

  assign colw      = (column_count >= cfg.width) ? 16'd0 : column_count;
  assign cols_left = cfg.width - colw;
  assign cnt8      = (cols_left > 16'd8) ? 4'd8 : cols_left[3:0];
  assign col_sum   = {1'b0, column_count} + {13'd0, bit_cnt};

  // v*target + max/2, target is 255 or 65535
  assign numer = (cfg.wide ? ({q_ev.data[15:0], 16'd0} - {16'd0, q_ev.data[15:0]})
                           : ({8'd0, q_ev.data[15:0], 8'd0} - {16'd0, q_ev.data[15:0]}))
                 + {17'd0, cfg.maxv[15:1]};
  assign trial = {rem, nq[15]};
  assign qbit  = trial >= {1'b0, cfg.maxv};

  assign ch      = (cfg.chans3 ? (chan_pos >= 2'd3) : (chan_pos >= 2'd1))
                   ? 2'd0 : chan_pos;
  assign ch_next = (cfg.chans3 ? (ch == 2'd2) : 1'b1) ? 2'd0 : ch + 2'd1;
  assign last    = samples_done + 34'd1 >= cfg.total;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      finished      <= 1'b0;
      samples_done  <= 34'd0;
      chan_pos      <= 2'd0;
      column_count  <= 16'd0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !emit_go) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid && !finished) begin
            unique case (q_ev.kind)
              EV_SAMPLE: begin
                if (q_ev.bad || q_ev.data > {1'b0, cfg.maxv}) begin
                  err_st   <= ST_CORRUPT;
                  finished <= 1'b1;
                  state    <= S_ERR;
                end else if (cfg.fmt == FMT_BITMAP) begin
                  val      <= q_ev.data[0] ? 16'd0 : 16'd255;
                  ret_bits <= 1'b0;
                  state    <= S_EMIT;
                end else begin
                  rem      <= numer[31:16];
                  nq       <= numer[15:0];
                  div_cnt  <= 4'd15;
                  ret_bits <= 1'b0;
                  state    <= S_DIV;
                end
              end
              EV_BITS: begin
                column_count <= colw;
                if (q_ev.eod && samples_done + {30'd0, cnt8} < cfg.total) begin
                  err_st   <= ST_TRUNC;
                  finished <= 1'b1;
                  state    <= S_ERR;
                end else begin
                  bits_byte <= q_ev.data[7:0];
                  bit_cnt   <= cnt8;
                  bit_idx   <= 4'd0;
                  state     <= S_BITS;
                end
              end
              EV_EOD: begin
                if (samples_done < cfg.total) begin
                  err_st <= ST_TRUNC;
                  state  <= S_ERR;
                end
                finished <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          rem <= qbit ? 16'(trial - {1'b0, cfg.maxv}) : trial[15:0];
          nq  <= {nq[14:0], qbit};
          if (div_cnt == 4'd0) begin
            state <= S_EMIT;
          end else begin
            div_cnt <= div_cnt - 4'd1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            sample_value  <= (cfg.fmt == FMT_BITMAP) ? val : nq;
            channel_index <= ch;
            status        <= ST_OK;
            last_sample   <= last;
            samples_done  <= samples_done + 34'd1;
            chan_pos      <= ch_next;
            if (last) finished <= 1'b1;
            state <= ret_bits ? S_BITS : S_IDLE;
          end
        end
        S_ERR: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            sample_value  <= 16'd0;
            channel_index <= 2'd0;
            status        <= err_st;
            last_sample   <= 1'b1;
            state         <= S_IDLE;
          end
        end
        S_BITS: begin
          if (bit_idx < bit_cnt && !finished) begin
            val       <= bits_byte[7] ? 16'd0 : 16'd255;
            bits_byte <= {bits_byte[6:0], 1'b0};
            bit_idx   <= bit_idx + 4'd1;
            ret_bits  <= 1'b1;
            state     <= S_EMIT;
          end else begin
            column_count <= (col_sum >= {1'b0, cfg.width}) ? 16'd0 : col_sum[15:0];
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/netpbm_pixel_decoder_top.sv @@
// ---------------------------------------------------------------------------
// netpbm_pixel_decoder_top: Netpbm raster decoder
// Configuration registers, decoded settings and the front/queue/back chain.
// ---------------------------------------------------------------------------
// Decodes PBM/PGM/PPM raster bytes (after the header) into rescaled samples.
// A byte is taken per cycle while the event queue has room and no second
// event of the last byte is pending. The sample engine takes one event at a
// time; for each gray or color sample it runs the divider and then drives the
// output register, and a binary bitmap byte gives up to 8 pixels. Set the
// registers only while the block is idle; the image size product is
// registered from the width and height registers.
`default_nettype none
module netpbm_pixel_decoder_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        psel,
  input  wire  logic        penable,
  input  wire  logic        pwrite,
  input  wire  logic [4:0]  paddr,
  input  wire  logic [31:0] pwdata,
  output       logic [31:0] prdata,
  output       logic        pready,
  input  wire  logic        in_valid,
  output       logic        in_stall,
  input  wire  logic [7:0]  data_byte,
  input  wire  logic        end_of_data,
  output       logic        out_valid,
  input  wire  logic        out_stall,
  output       logic [15:0] sample_value,
  output       logic [1:0]  channel_index,
  output       logic [1:0]  status,
  output       logic        last_sample
);
  import nppd_pkg::*;

  logic [1:0]  image_format;
  logic        ascii_mode;
  logic [15:0] max_sample, image_width, image_height;
  logic [31:0] wh;
  logic [15:0] h_eff;
  logic        wr;
  cfg_t        cfg;

  logic push_valid, q_full, q_valid, q_pop;
  ev_t  push_ev, q_ev;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_format  <= 2'd1;
      ascii_mode    <= 1'b0;
      max_sample    <= 16'd255;
      image_width   <= 16'd1;
      image_height  <= 16'd1;
      wh            <= 32'd1;
    end else begin
      if (wr) begin
        unique case (paddr[4:2])
          REG_FORMAT: image_format  <= pwdata[1:0];
          REG_ASCII:  ascii_mode    <= pwdata[0];
          REG_MAXV:   max_sample    <= pwdata[15:0];
          REG_WIDTH:  image_width   <= pwdata[15:0];
          REG_HEIGHT: image_height  <= pwdata[15:0];
          default: ;
        endcase
      end
      wh <= {16'd0, cfg.width} * {16'd0, h_eff};
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_FORMAT: prdata = {30'd0, image_format};
      REG_ASCII:  prdata = {31'd0, ascii_mode};
      REG_MAXV:   prdata = {16'd0, max_sample};
      REG_WIDTH:  prdata = {16'd0, image_width};
      REG_HEIGHT: prdata = {16'd0, image_height};
      default:    prdata = 32'd0;
    endcase
  end

  assign h_eff = (image_height == 16'd0) ? 16'd1 : image_height;

  always_comb begin
    cfg.fmt    = image_format;
    cfg.ascii  = ascii_mode;
    cfg.maxv   = (image_format == FMT_BITMAP) ? 16'd1 :
                 (max_sample == 16'd0) ? 16'd1 : max_sample;
    cfg.wide   = cfg.maxv > 16'd255;
    cfg.width  = (image_width == 16'd0) ? 16'd1 : image_width;
    cfg.chans3 = image_format[1];
    cfg.total  = cfg.chans3 ? ({2'd0, wh} + {1'b0, wh, 1'b0}) : {2'd0, wh};
  end

  nppd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .end_of_data(end_of_data),
    .push_valid (push_valid),
    .push_ev    (push_ev),
    .q_full     (q_full)
  );

  nppd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ev   (push_ev),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_ev    (q_ev),
    .pop       (q_pop)
  );

  nppd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_ev         (q_ev),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_value (sample_value),
    .channel_index(channel_index),
    .status       (status),
    .last_sample  (last_sample)
  );

endmodule
`default_nettype wire
